@@ rtl/pds_pkg.sv @@
// Package for the pairwise distance sorter: sizes, key layout, command and status types.
// Depends on nothing; used by pds_types, the datapath, the controller and the top level.
package pds_pkg;

    localparam int MaxPoints  = 64;
    localparam int PtIdxW     = $clog2(MaxPoints);
    localparam int PtCntW     = $clog2(MaxPoints + 1);
    localparam int PairDepth  = MaxPoints * (MaxPoints - 1) / 2;
    localparam int PairAddrW  = $clog2(PairDepth);
    localparam int PairCntW   = $clog2(PairDepth + 1);
    localparam int SqW        = 34;
    localparam int KeyW       = SqW + 16;
    localparam int DistW      = 17;
    localparam int IdxOutW    = 6;

    typedef logic [KeyW-1:0] key_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_SQRT  = 2'd1
    } dp_op_t;

    // controller -> datapath commands
    typedef struct packed {
        logic                 pt_we;
        logic [PtIdxW-1:0]    pt_waddr;
        logic [PtIdxW-1:0]    pt_raddr;
        logic                 pair_we;       // write key to pair bank
        logic                 pair_bank;     // bank being written
        logic [PairAddrW-1:0] pair_waddr;
        logic                 pair_rbank;
        logic [PairAddrW-1:0] pair_raddr;
        logic                 pair_wsel;     // 0: distance key, 1: merge winner
        logic                 take_a;        // latch read data as A
        logic                 take_b;
        logic                 take_pi;       // latch point i
        logic [PtIdxW-1:0]    idx_i;
        logic [PtIdxW-1:0]    idx_j;
        logic                 merge_pick_b;  // winner select when writing
        logic                 sqrt_start;
    } dp_cmd_t;

    typedef struct packed {
        logic b_less;      // key B < key A
        logic sqrt_done;
        key_t sel_key;
    } dp_stat_t;

endpackage

@@ rtl/pds_if.sv @@
// Valid/ready channel interface carrying one payload struct.
// Depends on nothing; payload type set at instantiation.
interface pds_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/pds_types.sv @@
// Payload structs for the two channels.
// Depends on pds_pkg.
package pds_types;
    import pds_pkg::*;
    typedef struct packed {
        logic        mode;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic        final_point;
    } in_item_t;
    typedef struct packed {
        logic [IdxOutW-1:0] first_index;
        logic [IdxOutW-1:0] second_index;
        logic [DistW-1:0]   distance;
        logic               last_pair;
        logic               empty_res;
    } out_item_t;
endpackage

@@ rtl/pds_datapath.sv @@
// Datapath: point memory, two pair banks, distance unit, key compare, iterative sqrt.
// Depends on pds_pkg.
module pds_datapath
    import pds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [31:0] pt_wdata,
    output dp_stat_t    stat,
    output logic [DistW-1:0] sqrt_root
);
    logic [31:0] pt_mem [MaxPoints];
    key_t        bank0 [PairDepth];
    key_t        bank1 [PairDepth];
    logic [31:0] pt_rd_reg;
    key_t        rd0_reg, rd1_reg;
    logic        rsel_reg;
    key_t        a_reg, b_reg;
    logic [31:0] pi_reg;
    logic [16:0] dx_reg, dy_reg;
    logic [SqW-1:0] sq_reg;
    key_t        dkey;
    key_t        wkey;
    key_t        rd;

    always_ff @(posedge clk)
    begin
        if (cmd.pt_we)
            pt_mem[cmd.pt_waddr] <= pt_wdata;
        pt_rd_reg <= pt_mem[cmd.pt_raddr];
    end

    assign rd = rsel_reg ? rd1_reg : rd0_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take_pi)
            pi_reg <= pt_rd_reg;
        if (cmd.take_a)
            a_reg <= rd;
        if (cmd.take_b)
            b_reg <= rd;
        dx_reg <= {1'b0, pi_reg[31:16]} - {1'b0, pt_rd_reg[31:16]};
        dy_reg <= {1'b0, pi_reg[15:0]} - {1'b0, pt_rd_reg[15:0]};
    end

    // abs then square; both squares and their sum in one register stage
    logic [15:0] adx, ady;
    assign adx = dx_reg[16] ? 16'(-dx_reg) : dx_reg[15:0];
    assign ady = dy_reg[16] ? 16'(-dy_reg) : dy_reg[15:0];
    always_ff @(posedge clk)
        sq_reg <= SqW'({16'd0, adx} * {16'd0, adx}) + SqW'({16'd0, ady} * {16'd0, ady});

    assign dkey = {sq_reg, 8'(cmd.idx_i), 8'(cmd.idx_j)};
    assign wkey = cmd.pair_wsel ? (cmd.merge_pick_b ? b_reg : a_reg) : dkey;

    always_ff @(posedge clk)
    begin
        if (cmd.pair_we && !cmd.pair_bank)
            bank0[cmd.pair_waddr] <= wkey;
        rd0_reg <= bank0[cmd.pair_raddr];
    end
    always_ff @(posedge clk)
    begin
        if (cmd.pair_we && cmd.pair_bank)
            bank1[cmd.pair_waddr] <= wkey;
        rd1_reg <= bank1[cmd.pair_raddr];
        rsel_reg <= cmd.pair_rbank;
    end

    // restoring square root, two radicand bits per cycle
    logic [SqW-1:0]  rem_reg, rem_next;
    logic [SqW-1:0]  rad_reg, rad_next;
    logic [DistW:0]  root_reg, root_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [SqW+1:0]  trial;
    logic [SqW+1:0]  shrem;

    always_comb
    begin
        shrem     = {rem_reg, rad_reg[SqW-1:SqW-2]};
        trial     = shrem - {{(SqW+2-DistW-3){1'b0}}, root_reg, 2'b01};
        rem_next  = rem_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (cmd.sqrt_start)
        begin
            rem_next  = '0;
            rad_next  = a_reg[KeyW-1:16];
            root_next = '0;
            cnt_next  = 5'(SqW / 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[SqW-3:0], 2'b00};
            if (!trial[SqW+1])
            begin
                rem_next  = trial[SqW-1:0];
                root_next = {root_reg[DistW-1:0], 1'b1};
            end
            else
            begin
                rem_next  = shrem[SqW-1:0];
                root_next = {root_reg[DistW-1:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
    end

    assign sqrt_root      = root_reg[DistW-1:0];
    assign stat.b_less    = b_reg < a_reg;
    assign stat.sqrt_done = !busy_reg && !cmd.sqrt_start;
    assign stat.sel_key   = a_reg;
endmodule

@@ rtl/pds_ctrl.sv @@
// Controller: load bookkeeping, pair generation, bottom-up merge sort, fetch sequencing.
// Depends on pds_pkg and pds_types.
module pds_ctrl
    import pds_pkg::*;
    import pds_types::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  logic      in_valid,
    output logic      in_ready,
    output out_item_t out_item,
    output logic      out_valid,
    input  logic      out_ready,
    output dp_cmd_t   cmd,
    input  dp_stat_t  stat,
    input  logic [DistW-1:0] sqrt_root
);
    typedef enum logic [3:0] {
        S_IDLE, S_GEN_PI, S_GEN_J, S_GEN_DRAIN,
        S_M_SETUP, S_M_RD, S_M_WAIT, S_M_CMP,
        S_F_RD, S_F_WAIT, S_F_START, S_F_SQRT, S_F_OUT
    } state_t;

    state_t               state_reg;
    logic [PtCntW-1:0]    loaded_reg;
    logic [PairCntW-1:0]  total_reg;
    logic [PairCntW-1:0]  fptr_reg;
    logic                 fin_reg;
    logic                 bank_reg;     // bank holding current sorted run data
    logic [PtIdxW-1:0]    i_reg, j_reg;
    logic [PtIdxW-1:0]    pi_d1, pj_d1, pi_d2, pj_d2, pi_d3, pj_d3;
    logic [2:0]           vld_d;
    logic [PairCntW-1:0]  k_reg;
    logic [PairCntW-1:0]  w_reg, lo_reg, a_reg, b_reg, mid_reg, hi_reg, o_reg;
    logic                 rd_b_reg;     // which side is being refilled
    logic                 both_reg;     // initial fill of both heads
    // point i read is issued in S_GEN_PI; data arrives in the next cycle
    logic                 gen_pi_d;
    logic                 gen_issue;
    logic [PairCntW-1:0]  m_raddr;

    function automatic logic [PairCntW-1:0] minp(input logic [PairCntW:0] x,
                                                  input logic [PairCntW-1:0] t);
        minp = (x < {1'b0, t}) ? x[PairCntW-1:0] : t;
    endfunction

    logic [PairCntW:0] n_ext;
    logic [PairCntW-1:0] npairs;
    always_comb
    begin
        n_ext  = (PairCntW+1)'(loaded_reg);
        npairs = (loaded_reg < PtCntW'(2)) ? '0 :
                 PairCntW'((n_ext * (n_ext - 1)) >> 1);
    end

    logic a_live, b_live, pick_b;
    assign a_live = a_reg < mid_reg;
    assign b_live = b_reg < hi_reg;
    assign pick_b = !a_live || (b_live && stat.b_less);

    assign in_ready  = (state_reg == S_IDLE) && !out_valid;
    assign gen_issue = (state_reg == S_GEN_J) && !gen_pi_d;
    assign m_raddr   = rd_b_reg ? b_reg : a_reg;

    always_comb
    begin
        cmd = '0;
        cmd.pt_waddr   = fin_reg ? '0 : loaded_reg[PtIdxW-1:0];
        cmd.pt_we      = in_valid && in_ready && !in_item.mode &&
                         (fin_reg || loaded_reg < PtCntW'(MaxPoints));
        cmd.pt_raddr   = (state_reg == S_GEN_PI) ? i_reg : j_reg;
        cmd.take_pi    = gen_pi_d;
        cmd.idx_i      = pi_d3;
        cmd.idx_j      = pj_d3;
        cmd.pair_we    = vld_d[2];
        cmd.pair_bank  = 1'b0;
        cmd.pair_waddr = k_reg[PairAddrW-1:0];
        cmd.pair_rbank = bank_reg;
        cmd.pair_raddr = m_raddr[PairAddrW-1:0];
        if (state_reg == S_M_WAIT)
        begin
            cmd.take_a = !rd_b_reg;
            cmd.take_b = rd_b_reg;
        end
        if (state_reg == S_M_CMP)
        begin
            cmd.pair_we      = 1'b1;
            cmd.pair_wsel    = 1'b1;
            cmd.pair_bank    = !bank_reg;
            cmd.pair_waddr   = o_reg[PairAddrW-1:0];
            cmd.merge_pick_b = pick_b;
        end
        if (state_reg == S_F_RD)
            cmd.pair_raddr = fptr_reg[PairAddrW-1:0];
        if (state_reg == S_F_WAIT)
            cmd.take_a = 1'b1;
        if (state_reg == S_F_START)
            cmd.sqrt_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            loaded_reg <= '0; total_reg <= '0; fptr_reg <= '0; fin_reg <= 1'b0;
            bank_reg <= 1'b0; i_reg <= '0; j_reg <= '0; vld_d <= '0; k_reg <= '0;
            pi_d1 <= '0; pj_d1 <= '0; pi_d2 <= '0; pj_d2 <= '0; pi_d3 <= '0; pj_d3 <= '0;
            w_reg <= '0; lo_reg <= '0; a_reg <= '0; b_reg <= '0; mid_reg <= '0;
            hi_reg <= '0; o_reg <= '0; rd_b_reg <= 1'b0; both_reg <= 1'b0;
            gen_pi_d <= 1'b0;
            out_valid <= 1'b0; out_item <= '0;
        end
        else
        begin
            gen_pi_d <= (state_reg == S_GEN_PI);
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            // distance pipe: addr -> mem rd -> dx/dy -> square -> write
            vld_d <= {vld_d[1:0], gen_issue};
            pi_d1 <= i_reg; pi_d2 <= pi_d1; pi_d3 <= pi_d2;
            pj_d1 <= j_reg; pj_d2 <= pj_d1; pj_d3 <= pj_d2;
            if (vld_d[2])
                k_reg <= k_reg + PairCntW'(1);
            case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready)
                    begin
                        if (!in_item.mode)
                        begin
                            if (fin_reg)
                            begin
                                fin_reg <= 1'b0;
                                fptr_reg <= '0;
                                loaded_reg <= PtCntW'(1);
                            end
                            else if (loaded_reg < PtCntW'(MaxPoints))
                                loaded_reg <= loaded_reg + PtCntW'(1);
                            if (in_item.final_point)
                            begin
                                state_reg <= S_GEN_PI;
                                i_reg <= '0;
                                k_reg <= '0;
                            end
                        end
                        else if (!fin_reg || fptr_reg >= total_reg)
                        begin
                            out_item <= '{first_index: '0, second_index: '0,
                                          distance: '0, last_pair: 1'b0,
                                          empty_res: 1'b1};
                            out_valid <= 1'b1;
                        end
                        else
                            state_reg <= S_F_RD;
                    end
                S_GEN_PI:
                begin
                    total_reg <= npairs;
                    fptr_reg  <= '0;
                    if (npairs == '0)
                    begin
                        fin_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        j_reg <= i_reg + PtIdxW'(1);
                        state_reg <= S_GEN_J;
                    end
                end
                S_GEN_J:
                    if (!gen_pi_d)
                    begin
                        if ((PtCntW)'(j_reg) + PtCntW'(1) == loaded_reg)
                        begin
                            if ((PtCntW)'(i_reg) + PtCntW'(2) == loaded_reg)
                                state_reg <= S_GEN_DRAIN;
                            else
                            begin
                                i_reg <= i_reg + PtIdxW'(1);
                                state_reg <= S_GEN_PI;
                            end
                        end
                        else
                            j_reg <= j_reg + PtIdxW'(1);
                    end
                S_GEN_DRAIN:
                    if (vld_d == '0 && !gen_pi_d)
                    begin
                        bank_reg <= 1'b0;
                        w_reg <= PairCntW'(1);
                        lo_reg <= '0;
                        state_reg <= S_M_SETUP;
                    end
                S_M_SETUP:
                    if (w_reg >= total_reg)
                    begin
                        fin_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (lo_reg >= total_reg)
                    begin
                        bank_reg <= !bank_reg;
                        w_reg <= w_reg << 1;
                        lo_reg <= '0;
                        // doubled width may not fit the counter; finish here
                        if (((PairCntW+1)'(w_reg) << 1) >= (PairCntW+1)'(total_reg))
                        begin
                            fin_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        a_reg   <= lo_reg;
                        o_reg   <= lo_reg;
                        mid_reg <= minp((PairCntW+1)'(lo_reg) + (PairCntW+1)'(w_reg), total_reg);
                        hi_reg  <= minp((PairCntW+1)'(lo_reg) + ((PairCntW+1)'(w_reg) << 1),
                                        total_reg);
                        b_reg   <= minp((PairCntW+1)'(lo_reg) + (PairCntW+1)'(w_reg), total_reg);
                        rd_b_reg <= 1'b0;
                        both_reg <= 1'b1;
                        state_reg <= S_M_RD;
                    end
                S_M_RD:
                    state_reg <= S_M_WAIT;
                S_M_WAIT:
                    if (both_reg)
                    begin
                        both_reg <= 1'b0;
                        rd_b_reg <= 1'b1;
                        state_reg <= S_M_RD;
                    end
                    else
                        state_reg <= S_M_CMP;
                S_M_CMP:
                begin
                    o_reg <= o_reg + PairCntW'(1);
                    rd_b_reg <= pick_b;
                    if (pick_b)
                        b_reg <= b_reg + PairCntW'(1);
                    else
                        a_reg <= a_reg + PairCntW'(1);
                    if (o_reg + PairCntW'(1) == hi_reg)
                    begin
                        lo_reg <= hi_reg;
                        state_reg <= S_M_SETUP;
                    end
                    else
                        state_reg <= S_M_RD;
                end
                S_F_RD:
                    state_reg <= S_F_WAIT;
                S_F_WAIT:
                    state_reg <= S_F_START;
                S_F_START:
                    state_reg <= S_F_SQRT;
                S_F_SQRT:
                    if (stat.sqrt_done)
                        state_reg <= S_F_OUT;
                S_F_OUT:
                begin
                    out_item <= '{first_index: stat.sel_key[8 +: IdxOutW],
                                  second_index: stat.sel_key[0 +: IdxOutW],
                                  distance: sqrt_root,
                                  last_pair: (fptr_reg + PairCntW'(1) == total_reg),
                                  empty_res: 1'b0};
                    out_valid <= 1'b1;
                    fptr_reg  <= fptr_reg + PairCntW'(1);
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/pairwise_distance_sorter.sv @@
// Channel    Dir  Payload
// in_ch      in   mode, point_x, point_y, final_point
// out_ch     out  first_index, second_index, distance, last_pair, empty_res
//
// Load: points are taken while idle. Final load: pair generation, then merge passes;
// each merged pair goes through S_M_RD, S_M_WAIT, S_M_CMP (one shared pair read address).
// Fetch: waits in S_F_SQRT on the 17-step square-root unit; an empty fetch answers from idle.
// Reset clears the controller and sqrt busy state; memories and datapath data are not cleared.
// A result waiting on out_ch blocks new requests until taken.
// Top level: pairs up controller and datapath. Depends on pds_pkg, pds_types, pds_if.
module pairwise_distance_sorter
    import pds_pkg::*;
    import pds_types::*;
(
    input  logic clk,
    input  logic rst_n,
    pds_if.sink   in_ch,
    pds_if.source out_ch
);
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [DistW-1:0] root;
    in_item_t  in_item;
    out_item_t out_item;

    assign in_item = in_ch.payload;
    assign out_ch.payload = out_item;

    pds_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_item(in_item), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_item(out_item), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .stat(stat), .sqrt_root(root)
    );

    pds_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .pt_wdata({in_item.point_x, in_item.point_y}),
        .stat(stat), .sqrt_root(root)
    );
endmodule

@@ rtl/pds_checker.sv @@
// Port-level checker for the sorter, bound to the top level.
// Depends on pds_types.
module pds_checker
    import pds_types::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result dropped under stall");
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while result pending");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.empty_res |-> out_item.distance == 0 && !out_item.last_pair)
        else $error("empty result carries data");
    a_last_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.last_pair |-> !out_item.empty_res)
        else $error("last and empty together");
endmodule

bind pairwise_distance_sorter pds_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_item(out_ch.payload)
);
